@@ rtl/pcsdp_pkg.sv @@
// shared types and constants for the packed code scaled dot product
`default_nettype none

package pcsdp_pkg;

  localparam int LANES       = 4;
  localparam int CODE_W      = 8;
  localparam int ACT_W       = 32;
  localparam int LANE_PROD_W = CODE_W + ACT_W;
  localparam int ACC_W       = 64;
  localparam int WIDE_W      = ACC_W + ACT_W;
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int IN_DATA_W   = 176;
  localparam int OUT_DATA_W  = 64;
  localparam int FRAC_W      = 16;

  // code width selector values
  localparam logic [1:0] WSEL_2BIT   = 2'd0;
  localparam logic [1:0] WSEL_4BIT   = 2'd1;
  localparam logic [1:0] WSEL_8BIT   = 2'd2;
  localparam logic [1:0] WSEL_UNUSED = 2'd3;
  localparam logic [1:0] WSEL_RESET  = WSEL_4BIT;

  localparam logic [ACC_W-1:0] SAT_POS = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] SAT_NEG = {1'b1, {(ACC_W-1){1'b0}}};

  typedef logic signed [CODE_W-1:0] code_t;
  typedef logic signed [ACT_W-1:0]  act_t;

  // one classified item as it waits in the queue; unused lanes carry code zero
  typedef struct packed {
    code_t [LANES-1:0] codes;
    act_t  [LANES-1:0] acts;
    act_t              row_scale;
    logic              is_last;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_MAG,
    ST_PROD,
    ST_SUM,
    ST_SAT
  } back_state_t;

endpackage

`default_nettype wire

@@ rtl/packed_code_scaled_dot_product.sv @@
// Packed low-bit code dot product with row scaling. Each input transfer carries
// one byte of signed 2-, 4- or 8-bit codes (width set by code_width_sel) and up
// to four Q16.16 activations; valid lanes are multiplied and added into a 64-bit
// accumulator, and the transfer marked tlast scales the total by row_scale,
// rounds half away from zero, saturates and sends one result. The front end
// accepts one transfer per cycle while its four-entry queue is not full; the
// back end takes an ordinary item through queue pop, lane multiply and
// accumulate, and a last item also through magnitude, two 32x32 partial
// products, wide add and clip; it pops no new item until the current one is done.
// A waiting result holds the back end only once a last item reaches the clip step.
`default_nettype none

module packed_code_scaled_dot_product (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [1:0]                       cfg_wr_data,  // code_width_sel
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // code_byte, act_lane0, act_lane1, act_lane2, act_lane3, valid_lanes, row_scale
  input  wire logic [pcsdp_pkg::IN_DATA_W-1:0]  s_tdata,
  input  wire logic                             s_tlast,      // is_last
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [pcsdp_pkg::OUT_DATA_W-1:0]      m_tdata,      // row_result
  output logic                                  m_tuser       // saturated
);
  import pcsdp_pkg::*;

  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  entry_t push_entry;
  entry_t pop_entry;

  pcsdp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .q_push      (q_push),
    .q_entry     (push_entry),
    .q_full      (q_full)
  );

  pcsdp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  pcsdp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_entry  (pop_entry),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

@@ rtl/pcsdp_front.sv @@
// front end: width register, lane decode and queue push
`default_nettype none

module pcsdp_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [1:0]                     cfg_wr_data,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [pcsdp_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic                           s_tlast,
  output logic                                q_push,
  output pcsdp_pkg::entry_t                   q_entry,
  input  wire logic                           q_full
);
  import pcsdp_pkg::*;

  logic [1:0]       code_width_sel;
  logic [7:0]       code_byte;
  logic [2:0]       valid_lanes;
  logic [2:0]       max_lanes;
  logic [2:0]       n_lanes;
  code_t [LANES-1:0] raw_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_width_sel <= WSEL_RESET;
    end else if (cfg_wr_en) begin
      code_width_sel <= cfg_wr_data;
    end
  end

  assign code_byte   = s_tdata[7:0];
  assign valid_lanes = s_tdata[138:136];

  always_comb begin
    raw_code = '0;
    unique case (code_width_sel)
      WSEL_2BIT: begin
        max_lanes = 3'd4;
        for (int k = 0; k < LANES; k++) begin
          raw_code[k] = CODE_W'(signed'(code_byte[2*k +: 2]));
        end
      end
      WSEL_4BIT: begin
        max_lanes = 3'd2;
        for (int k = 0; k < 2; k++) begin
          raw_code[k] = CODE_W'(signed'(code_byte[4*k +: 4]));
        end
      end
      default: begin
        // 8-bit codes, also taken for the unused selector value
        max_lanes   = 3'd1;
        raw_code[0] = signed'(code_byte);
      end
    endcase
  end

  assign n_lanes = (valid_lanes > max_lanes) ? max_lanes : valid_lanes;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      q_entry.codes[k] = (3'(k) < n_lanes) ? raw_code[k] : '0;
    end
    q_entry.acts[0]   = s_tdata[39:8];
    q_entry.acts[1]   = s_tdata[71:40];
    q_entry.acts[2]   = s_tdata[103:72];
    q_entry.acts[3]   = s_tdata[135:104];
    q_entry.row_scale = s_tdata[170:139];
    q_entry.is_last   = s_tlast;
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

endmodule

`default_nettype wire

@@ rtl/pcsdp_queue.sv @@
// short queue of classified items between front and back end
`default_nettype none

module pcsdp_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire pcsdp_pkg::entry_t push_entry,
  output logic                   full,
  input  wire logic              pop,
  output pcsdp_pkg::entry_t      pop_entry,
  output logic                   empty
);
  import pcsdp_pkg::*;

  entry_t          slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign pop_entry = slots[rd_ptr];
  assign full      = (count == (Q_AW+1)'(Q_DEPTH));
  assign empty     = (count == '0);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ rtl/pcsdp_back.sv @@
// back end: lane products, accumulator and row scaling with round and saturate
`default_nettype none

module pcsdp_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            q_empty,
  output logic                                 q_pop,
  input  wire pcsdp_pkg::entry_t               q_entry,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [pcsdp_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                 m_tuser
);
  import pcsdp_pkg::*;

  back_state_t state, state_next;

  entry_t                        ent;
  logic signed [LANE_PROD_W-1:0] lane_prod [LANES];
  logic [ACC_W-1:0]              acc;
  logic [ACC_W-1:0]              acc_sum;
  logic [ACC_W-1:0]              acc_fin;
  logic [ACC_W-1:0]              am;
  logic [ACT_W-1:0]              sm;
  logic                          neg;
  logic [ACC_W-1:0]              pp_lo;
  logic [ACC_W-1:0]              pp_hi;
  logic [WIDE_W-1:0]             wide;
  logic [ACC_W-1:0]              mag;
  logic [ACC_W-1:0]              limit;
  logic                          sat;
  logic [ACC_W-1:0]              res;
  logic                          out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = ent.is_last ? ST_MAG : ST_IDLE;
      ST_MAG:  state_next = ST_PROD;
      ST_PROD: state_next = ST_SUM;
      ST_SUM:  state_next = ST_SAT;
      ST_SAT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign acc_sum = acc + 64'(lane_prod[0]) + 64'(lane_prod[1])
                       + 64'(lane_prod[2]) + 64'(lane_prod[3]);

  // round half away from zero on the magnitude, then clip
  assign mag   = wide[FRAC_W +: ACC_W];
  assign limit = neg ? SAT_NEG : SAT_POS;
  assign sat   = (wide[WIDE_W-1:FRAC_W+ACC_W] != '0) || (mag > limit);
  assign res   = sat ? limit : (neg ? (~mag + 1'b1) : mag);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent <= q_entry;
    end
    if (state == ST_MUL) begin
      for (int k = 0; k < LANES; k++) begin
        lane_prod[k] <= LANE_PROD_W'(ent.codes[k]) * LANE_PROD_W'(ent.acts[k]);
      end
    end
    if (state == ST_ACC) begin
      acc_fin <= acc_sum;
    end
    if (state == ST_MAG) begin
      am  <= acc_fin[ACC_W-1] ? (~acc_fin + 1'b1) : acc_fin;
      sm  <= ent.row_scale[ACT_W-1] ? (~ent.row_scale + 1'b1) : ent.row_scale;
      neg <= acc_fin[ACC_W-1] ^ ent.row_scale[ACT_W-1];
    end
    if (state == ST_PROD) begin
      pp_lo <= ACC_W'(am[ACT_W-1:0]) * ACC_W'(sm);
      pp_hi <= ACC_W'(am[ACC_W-1:ACT_W]) * ACC_W'(sm);
    end
    if (state == ST_SUM) begin
      wide <= WIDE_W'(pp_lo) + {pp_hi, {ACT_W{1'b0}}}
              + WIDE_W'({1'b1, {(FRAC_W-1){1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (state == ST_ACC) begin
      acc <= ent.is_last ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_SAT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SAT && out_free) begin
      m_tdata <= res;
      m_tuser <= sat;
    end
  end

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == SAT_POS || m_tdata == SAT_NEG))
    else $error("saturated result is not a range limit");

  a_out_from_sat: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_SAT))
    else $error("result raised outside the final state");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC && ent.is_last) |=> (acc == '0))
    else $error("accumulator not cleared after last item");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// self-checking testbench for the packed code scaled dot product block
`timescale 1ns / 1ps

module tb_top;
  import pcsdp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_WAIT  = 40;   // back end may still hold non-last items
  localparam int HOLD_CYCLES  = 500;
  localparam int IDLE_PCT     = 15;
  localparam int PHASE_ITEMS  = 170;
  localparam int SAT_ROW_LEN  = 1040;

  localparam act_t ACT_MAX = 32'sh7FFF_FFFF;
  localparam act_t ACT_MIN = 32'sh8000_0000;
  localparam act_t ACT_ONE = 32'sh0001_0000;
  localparam act_t ACT_LSB = 32'sh0000_0001;
  localparam act_t HALF_LSB = 32'sh0000_8000;
  localparam act_t UNDER_HALF = 32'sh0000_7FFF;

  typedef struct packed {
    logic [7:0]        code_byte;
    act_t [LANES-1:0]  acts;
    logic [2:0]        valid_lanes;
    act_t              row_scale;
    logic              is_last;
  } row_item_t;

  typedef struct packed {
    logic [OUT_DATA_W-1:0] row_result;
    logic                  saturated;
  } row_out_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [1:0]            cfg_wr_data = 2'd0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // code_byte, act_lane0, act_lane1, act_lane2, act_lane3, valid_lanes, row_scale
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;     // is_last
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;            // row_result
  logic                  m_tuser;            // saturated

  packed_code_scaled_dot_product dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  row_item_t        pending_items[$];
  row_out_t         row_expect_q[$];
  row_item_t        offered_item;
  row_out_t         seen_row;
  logic [1:0]       width_sel = WSEL_RESET;
  logic signed [63:0] dot_acc = '0;
  int               fail_cnt = 0;
  int               cycle_cnt = 0;
  int               hold_left = 0;
  logic             hold_go = 1'b0;
  logic             idle_on = 1'b1;

  // mirror of the accumulator: add the item's lanes, close the row on last
  function automatic void absorb_item(input row_item_t it);
    int unsigned       bits;
    int unsigned       lanes;
    int unsigned       k;
    logic [7:0]        field;
    logic signed [63:0] code;
    logic signed [63:0] act64;
    logic [63:0]       amag;
    logic [31:0]       smag;
    logic [127:0]      prod;
    logic [127:0]      rnd;
    logic [63:0]       limit;
    logic [63:0]       mag;
    logic              neg;
    row_out_t          res;

    bits = (width_sel == WSEL_2BIT) ? 2 : (width_sel == WSEL_4BIT) ? 4 : 8;
    lanes = it.valid_lanes;
    if (lanes > 8 / bits) lanes = 8 / bits;
    for (k = 0; k < lanes; k++) begin
      field = (it.code_byte >> (k * bits)) & ((8'd1 << bits) - 8'd1);
      code = {56'd0, field};
      if (field[bits-1]) code = code - (64'sd1 <<< bits);
      act64 = $signed(it.acts[k]);
      dot_acc = dot_acc + code * act64;
    end
    if (!it.is_last) return;

    neg  = dot_acc[63] ^ it.row_scale[31];
    amag = dot_acc[63] ? (~dot_acc + 64'd1) : dot_acc;
    smag = it.row_scale[31] ? (~it.row_scale + 32'd1) : it.row_scale;
    prod = {64'd0, amag} * {96'd0, smag};
    // round half away from zero on the magnitude
    rnd  = (prod + 128'h8000) >> 16;
    limit = neg ? SAT_NEG : SAT_POS;
    res.saturated = (rnd > {64'd0, limit});
    mag = res.saturated ? limit : rnd[63:0];
    res.row_result = neg ? (~mag + 64'd1) : mag;
    row_expect_q.push_back(res);
    dot_acc = '0;
  endfunction

  function automatic row_item_t make_item(input logic [7:0] code, input act_t a0,
                                          input act_t a1, input act_t a2, input act_t a3,
                                          input logic [2:0] lanes, input act_t scale,
                                          input logic last);
    row_item_t it;
    it.code_byte   = code;
    it.acts[0]     = a0;
    it.acts[1]     = a1;
    it.acts[2]     = a2;
    it.acts[3]     = a3;
    it.valid_lanes = lanes;
    it.row_scale   = scale;
    it.is_last     = last;
    return it;
  endfunction

  function automatic act_t rand_q16();
    case ($urandom_range(5))
      0: return ACT_MAX;
      1: return ACT_MIN;
      2: return act_t'($urandom_range(262143)) - 32'sd131072;
      default: return act_t'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] rand_lanes();
    if ($urandom_range(9) == 0) return 3'($urandom_range(7));
    return 3'($urandom_range(1, 4));
  endfunction

  // rows of random content, mostly short, now and then long
  task automatic queue_rows(input int count);
    int pushed;
    int len;
    int i;
    pushed = 0;
    while (pushed < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      for (i = 0; i < len; i++) begin
        pending_items.push_back(make_item(8'($urandom_range(255)), rand_q16(), rand_q16(),
                                          rand_q16(), rand_q16(), rand_lanes(), rand_q16(),
                                          i == len - 1));
      end
      pushed += len;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || s_tvalid || row_expect_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_code_width(input logic [1:0] sel);
    wait_drained();
    repeat (SETTLE_WAIT) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sel;
    width_sel = sel;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // sender: predict on each accepted transfer, then offer the next pending item
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) absorb_item(offered_item);
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() != 0 && !(idle_on && $urandom_range(99) < IDLE_PCT)) begin
          offered_item = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {5'd0, offered_item.row_scale, offered_item.valid_lanes,
                       offered_item.acts[3], offered_item.acts[2], offered_item.acts[1],
                       offered_item.acts[0], offered_item.code_byte};
          s_tlast  <= offered_item.is_last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver: compare each result transfer with the oldest expected row
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (row_expect_q.size() == 0) begin
          $error("unexpected result transfer: row_result %h saturated %b", m_tdata, m_tuser);
          fail_cnt++;
        end else begin
          seen_row = row_expect_q.pop_front();
          if (m_tdata !== seen_row.row_result) begin
            $error("row_result: expected %h, actual %h", seen_row.row_result, m_tdata);
            fail_cnt++;
          end
          if (m_tuser !== seen_row.saturated) begin
            $error("saturated: expected %b, actual %b", seen_row.saturated, m_tuser);
            fail_cnt++;
          end
        end
      end
      m_tready <= (hold_left == 0) && !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    logic [1:0] phase_sel[5];
    int i;
    phase_sel = '{WSEL_2BIT, WSEL_4BIT, WSEL_8BIT, WSEL_UNUSED, WSEL_2BIT};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // 4-bit codes from reset: lane extremes, lane count clamp, zero lanes, zero row
    pending_items.push_back(make_item(8'h87, ACT_MAX, ACT_MIN, '0, '0, 3'd2, '0, 1'b0));
    pending_items.push_back(make_item(8'h8F, ACT_ONE, ACT_ONE, ACT_MAX, ACT_MAX, 3'd4, '0,
                                      1'b0));
    pending_items.push_back(make_item(8'h7F, ACT_ONE, ACT_ONE, '0, '0, 3'd0, ACT_ONE, 1'b1));
    pending_items.push_back(make_item(8'h00, ACT_MAX, ACT_MAX, '0, '0, 3'd2, ACT_MIN, 1'b1));

    set_code_width(WSEL_2BIT);
    pending_items.push_back(make_item(8'hE4, ACT_MAX, ACT_MAX, ACT_MAX, ACT_MAX, 3'd4, '0,
                                      1'b0));
    pending_items.push_back(make_item(8'h1B, ACT_MIN, ACT_MIN, ACT_MIN, ACT_MIN, 3'd7, '0,
                                      1'b0));
    pending_items.push_back(make_item(8'hAA, ACT_ONE, ACT_ONE, ACT_ONE, ACT_ONE, 3'd3,
                                      ACT_MAX, 1'b1));

    // 8-bit codes: rounding ties both signs, just under a tie, largest product
    set_code_width(WSEL_8BIT);
    pending_items.push_back(make_item(8'h01, ACT_LSB, '0, '0, '0, 3'd1, HALF_LSB, 1'b1));
    pending_items.push_back(make_item(8'hFF, ACT_LSB, '0, '0, '0, 3'd1, HALF_LSB, 1'b1));
    pending_items.push_back(make_item(8'h01, ACT_LSB, '0, '0, '0, 3'd1, UNDER_HALF, 1'b1));
    pending_items.push_back(make_item(8'h80, ACT_MIN, ACT_MIN, ACT_MIN, ACT_MIN, 3'd4,
                                      ACT_MIN, 1'b1));
    pending_items.push_back(make_item(8'h7F, ACT_MAX, '0, '0, '0, 3'd5, '0, 1'b0));
    pending_items.push_back(make_item(8'h80, ACT_MAX, ACT_MAX, '0, '0, 3'd6, ACT_MAX, 1'b1));

    // unused selector behaves as 8-bit codes
    set_code_width(WSEL_UNUSED);
    pending_items.push_back(make_item(8'h81, ACT_ONE, ACT_MAX, '0, '0, 3'd2, ACT_ONE, 1'b1));
    pending_items.push_back(make_item(8'h40, ACT_MIN, '0, '0, '0, 3'd1, '0, 1'b0));
    pending_items.push_back(make_item(8'hC0, ACT_MAX, '0, '0, '0, 3'd3, ACT_MAX, 1'b1));

    // one row long enough that the scaled total clips
    set_code_width(WSEL_8BIT);
    for (i = 0; i < SAT_ROW_LEN; i++) begin
      pending_items.push_back(make_item(8'h80, ACT_MIN + act_t'($urandom_range(65535)),
                                        rand_q16(), rand_q16(), rand_q16(),
                                        3'($urandom_range(1, 4)),
                                        $urandom_range(1) ? ACT_MAX : ACT_MIN,
                                        i == SAT_ROW_LEN - 1));
    end

    for (i = 0; i < 5; i++) begin
      set_code_width(phase_sel[i]);
      idle_on = (i != 1);
      queue_rows(PHASE_ITEMS);
      if (i == 0) begin
        // results back up while the sender keeps going
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
    end

    wait_drained();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (row_expect_q.size() != 0) begin
      $error("row_result: %0d expected rows never arrived", row_expect_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/pcsdp_pkg.sv
rtl/pcsdp_front.sv
rtl/pcsdp_queue.sv
rtl/pcsdp_back.sv
rtl/packed_code_scaled_dot_product.sv
tb/tb_top.sv
